// ----- hdl/csq_pkg.sv -----
// Shared constants and types for the charger setting quantizer.
// Used by csq_decode, csq_code_store and charger_setting_quantizer; no dependencies.
package csq_pkg;

    localparam int NumSettings = 9;
    localparam int SelWidth    = 4;
    localparam int CodeWidth   = 8;
    localparam int ValWidth    = 24;

    typedef logic [SelWidth-1:0]  sel_t;
    typedef logic [CodeWidth-1:0] code_t;
    typedef logic [ValWidth-1:0]  value_t;

    localparam sel_t SelSafeCurrent  = 4'd0;
    localparam sel_t SelCurrentLimit = 4'd1;
    localparam sel_t SelUsbLimit     = 4'd2;
    localparam sel_t SelDcLimit      = 4'd3;
    localparam sel_t SelSafeVoltage  = 4'd4;
    localparam sel_t SelMaxVoltage   = 4'd5;
    localparam sel_t SelWeak         = 4'd6;
    localparam sel_t SelRecharge     = 4'd7;
    localparam sel_t SelInputMin     = 4'd8;

    localparam logic OpWrite = 1'b0;
    localparam logic OpRead  = 1'b1;

    localparam logic StatusOk    = 1'b0;
    localparam logic StatusError = 1'b1;

    function automatic value_t range_min(input sel_t sel);
        value_t v;
        case (sel) inside
            SelSafeCurrent, SelCurrentLimit:             v = 24'd200000;
            SelUsbLimit, SelDcLimit:                     v = 24'd100000;
            SelSafeVoltage, SelMaxVoltage, SelRecharge:  v = 24'd3240000;
            SelWeak:                                     v = 24'd2100000;
            default:                                     v = 24'd4200000;
        endcase
        return v;
    endfunction

    function automatic value_t range_max(input sel_t sel);
        value_t v;
        case (sel) inside
            SelSafeCurrent, SelCurrentLimit:             v = 24'd3000000;
            SelUsbLimit, SelDcLimit:                     v = 24'd2500000;
            SelSafeVoltage, SelMaxVoltage, SelRecharge:  v = 24'd5000000;
            SelWeak:                                     v = 24'd3600000;
            default:                                     v = 24'd9600000;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/charger_setting_quantizer.sv -----
// Top level of the charger setting quantizer: sequencer, code search and result register.
// Depends on csq_pkg, csq_decode and csq_code_store.
//
//  Channel  Direction  Ports
//  s_       in         s_valid, s_ready, s_opcode, s_setting_select, s_requested_value
//  m_       out        m_valid, m_ready, m_status, m_hw_code, m_setting_value,
//                      m_was_clamped, m_was_rounded
//
// A read or rejected write passes through check and finish before its result is registered;
// an unknown selector goes straight to finish. An accepted write passes through check, a clamp
// state for the two limits, one search step per code tried by the linear search through the
// decode unit, and the finish. In-range values end the search by code 177.
// Reset clears all stored codes to zero. The input is ready only while the sequencer is idle;
// a finished result waits in the output register and the sequencer holds while it is full.
module charger_setting_quantizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [3:0]          s_setting_select,
    input  logic [23:0]         s_requested_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_status,
    output logic [7:0]          m_hw_code,
    output logic [23:0]         m_setting_value,
    output logic                m_was_clamped,
    output logic                m_was_rounded
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_CLAMP  = 3'd2;
    localparam logic [2:0] ST_SEARCH = 3'd3;
    localparam logic [2:0] ST_FINAL  = 3'd4;

    logic [2:0]      state_reg, state_next;
    logic            op_reg;
    csq_pkg::sel_t   sel_reg;
    csq_pkg::value_t val_reg, val_next;
    csq_pkg::code_t  code_reg, code_next;
    logic            status_reg, status_next;
    logic            clamped_reg, clamped_next;
    logic            wr_ok_reg, wr_ok_next;
    logic            bad_sel_reg;

    logic            m_valid_reg;
    logic            m_status_reg;
    csq_pkg::code_t  m_hw_code_reg;
    csq_pkg::value_t m_setting_value_reg;
    logic            m_was_clamped_reg;
    logic            m_was_rounded_reg;

    csq_pkg::sel_t   rd_addr;
    csq_pkg::code_t  rd_data;
    csq_pkg::value_t dec_value;
    logic            in_range;
    logic            clamp_sel;
    logic            dec_gt;
    logic            out_free;
    logic            finish;
    logic            accept;

    csq_decode u_decode (
        .sel   (sel_reg),
        .code  (code_reg),
        .value (dec_value)
    );

    csq_code_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (finish && wr_ok_reg),
        .wr_addr (sel_reg),
        .wr_data (code_reg)
    );

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_range  = (val_reg >= csq_pkg::range_min(sel_reg)) &&
                       (val_reg <= csq_pkg::range_max(sel_reg));
    assign clamp_sel = (sel_reg == csq_pkg::SelCurrentLimit) ||
                       (sel_reg == csq_pkg::SelMaxVoltage);
    assign dec_gt    = dec_value > val_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign finish    = (state_reg == ST_FINAL) && out_free;

    always_comb begin
        rd_addr = sel_reg;
        if (op_reg == csq_pkg::OpWrite && in_range && clamp_sel) begin
            rd_addr = (sel_reg == csq_pkg::SelCurrentLimit) ? csq_pkg::SelSafeCurrent
                                                            : csq_pkg::SelSafeVoltage;
        end
    end

    always_comb begin
        state_next   = state_reg;
        val_next     = val_reg;
        code_next    = code_reg;
        status_next  = status_reg;
        clamped_next = clamped_reg;
        wr_ok_next   = wr_ok_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    val_next     = s_requested_value;
                    code_next    = '0;
                    status_next  = csq_pkg::StatusOk;
                    clamped_next = 1'b0;
                    wr_ok_next   = 1'b0;
                    if (s_setting_select >= 4'(csq_pkg::NumSettings)) begin
                        status_next = csq_pkg::StatusError;
                        state_next  = ST_FINAL;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                code_next = rd_data;
                if (op_reg == csq_pkg::OpRead) begin
                    state_next = ST_FINAL;
                end else if (!in_range) begin
                    status_next = csq_pkg::StatusError;
                    state_next  = ST_FINAL;
                end else begin
                    wr_ok_next = 1'b1;
                    if (clamp_sel) begin
                        state_next = ST_CLAMP;
                    end else begin
                        code_next  = '0;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_CLAMP: begin
                if (dec_value < val_reg) begin
                    val_next     = dec_value;
                    clamped_next = 1'b1;
                end
                code_next  = '0;
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (dec_gt) begin
                    code_next  = (code_reg == '0) ? '0 : code_reg - 8'd1;
                    state_next = ST_FINAL;
                end else if (code_reg == '1) begin
                    state_next = ST_FINAL;
                end else begin
                    code_next = code_reg + 8'd1;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        code_reg    <= code_next;
        status_reg  <= status_next;
        clamped_reg <= clamped_next;
        wr_ok_reg   <= wr_ok_next;
        if (accept) begin
            op_reg      <= s_opcode;
            sel_reg     <= s_setting_select;
            bad_sel_reg <= (s_setting_select >= 4'(csq_pkg::NumSettings));
        end
        if (finish) begin
            m_status_reg        <= status_reg;
            m_hw_code_reg       <= code_reg;
            m_setting_value_reg <= bad_sel_reg ? '0 : dec_value;
            m_was_clamped_reg   <= clamped_reg;
            m_was_rounded_reg   <= wr_ok_reg && (dec_value != val_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_hw_code       = m_hw_code_reg;
    assign m_setting_value = m_setting_value_reg;
    assign m_was_clamped   = m_was_clamped_reg;
    assign m_was_rounded   = m_was_rounded_reg;

endmodule

// ----- hdl/csq_decode.sv -----
// Shared decode unit: piecewise-linear value of one setting code, saturated to 24 bits.
// Depends on csq_pkg.
module csq_decode (
    input  csq_pkg::sel_t   sel,
    input  csq_pkg::code_t  code,
    output csq_pkg::value_t value
);

    logic [26:0] base;
    logic [17:0] step;
    logic [7:0]  mcode;
    logic [25:0] product;
    logic [26:0] sum;

    always_comb begin
        base  = '0;
        step  = '0;
        mcode = code;
        case (sel) inside
            csq_pkg::SelSafeCurrent, csq_pkg::SelCurrentLimit: begin
                step = 18'd50000;
            end
            csq_pkg::SelUsbLimit, csq_pkg::SelDcLimit: begin
                if (code < 8'd2) begin
                    base = 27'd100000;
                    step = 18'd50000;
                end else begin
                    step = 18'd100000;
                end
            end
            csq_pkg::SelSafeVoltage, csq_pkg::SelMaxVoltage: begin
                base = 27'd3240000;
                step = 18'd10000;
            end
            csq_pkg::SelWeak: begin
                base = 27'd2100000;
                step = 18'd100000;
            end
            csq_pkg::SelRecharge: begin
                base = 27'd3240000;
                step = 18'd20000;
            end
            default: begin
                if (code > 8'd42) begin
                    base  = 27'd5600000;
                    step  = 18'd200000;
                    mcode = code - 8'd43;
                end else begin
                    base = 27'd3400000;
                    step = 18'd50000;
                end
            end
        endcase
        product = 26'(mcode) * 26'(step);
        sum     = {1'b0, product} + base;
        value   = (sum > 27'hFFFFFF) ? '1 : sum[23:0];
    end

endmodule

// ----- hdl/csq_code_store.sv -----
// Register file of stored setting codes, one read port and one write port.
// Depends on csq_pkg.
module csq_code_store (
    input  logic            aclk,
    input  logic            aresetn,
    input  csq_pkg::sel_t   rd_addr,
    output csq_pkg::code_t  rd_data,
    input  logic            wr_en,
    input  csq_pkg::sel_t   wr_addr,
    input  csq_pkg::code_t  wr_data
);

    csq_pkg::code_t codes_reg [csq_pkg::NumSettings];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < csq_pkg::NumSettings; i++) begin
                codes_reg[i] <= '0;
            end
        end else if (wr_en) begin
            codes_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = codes_reg[rd_addr];

endmodule
